// ----- design/bdq_pkg.sv -----
// Package for the bounded deque with search.
// Holds the depth, derived widths, opcode, status and state types, and the
// memory request struct. No dependencies.
package bdq_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W = 32;
  localparam int POSITION_W = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_FIND       = 3'd4,
    OP_READ       = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } mem_req_t;

endpackage

// ----- design/bdq_if.sv -----
// Request and response channel interfaces for the bounded deque.
// Depends on bdq_pkg for the field widths.
interface bdq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [bdq_pkg::OPCODE_W-1:0]   opcode;
  logic signed [bdq_pkg::VALUE_W-1:0]    value;
  logic        [bdq_pkg::POSITION_W-1:0] position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink (input valid, input opcode, input value, input position, output ready);
endinterface

interface bdq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic        [bdq_pkg::STATUS_W-1:0]   status;
  logic signed [bdq_pkg::VALUE_W-1:0]    result_value;
  logic        [bdq_pkg::POSITION_W-1:0] result_position;
  logic        [bdq_pkg::COUNT_W-1:0]    entry_count;

  modport source (output valid, output status, output result_value,
                  output result_position, output entry_count, input ready);
  modport sink (input valid, input status, input result_value,
                input result_position, input entry_count, output ready);
endinterface

// ----- design/bounded_deque_with_search.sv -----
// Top level of the bounded deque with search: sequencer, pointers and output register.
// Depends on bdq_pkg, bdq_if, bdq_store and bdq_alu.
//
// Requests arrive on req (opcode, value, position) and each one gives exactly
// one response on rsp (status, result_value, result_position, entry_count).
// A request is taken when req.valid and req.ready are both high; req.ready is
// high only while the sequencer is idle, so one request is worked on at a time.
// Pushes, pops and invalid opcodes pass through S_EXEC and S_FIN, a read at a
// valid index also passes S_RDWAIT, and a find on a non-empty deque scans in
// S_SCAN, where the shared comparator checks one stored entry per cycle against the
// registered read port of the entry store.
// Back to back, a new request is taken only once the previous one has left S_FIN
// and the sequencer is idle again.
// The response sits in an output register; if rsp.ready is low the next request
// is still taken and worked on, and its result waits in the sequencer until the
// output register frees up.
// Synchronous reset empties the deque and clears the front pointer; stored
// entries are not cleared and are never read before being written.
module bounded_deque_with_search (
  input  logic           clk,
  input  logic           rst,
  bdq_in_if.sink         req,
  bdq_out_if.source      rsp
);

  bdq_pkg::state_t              state, state_next;
  bdq_pkg::op_t                 op;
  logic [bdq_pkg::VALUE_W-1:0]  val;
  logic [bdq_pkg::POSITION_W-1:0] pos;
  logic [bdq_pkg::PTR_W-1:0]    front, front_next;
  logic [bdq_pkg::CNT_W-1:0]    count, count_next;
  logic [bdq_pkg::CNT_W-1:0]    idx, idx_next;
  logic                         pend, pend_next;
  logic [bdq_pkg::PTR_W-1:0]    pend_idx, pend_idx_next;
  bdq_pkg::status_t             res_status, res_status_next;
  logic [bdq_pkg::VALUE_W-1:0]  res_value, res_value_next;
  logic [bdq_pkg::PTR_W-1:0]    res_pos, res_pos_next;

  bdq_pkg::mem_req_t            mreq;
  logic [bdq_pkg::VALUE_W-1:0]  rdata;
  logic [bdq_pkg::PTR_W-1:0]    alu_offset;
  logic [bdq_pkg::PTR_W-1:0]    alu_addr;
  logic                         alu_eq;

  logic full, empty, pos_ok, issue, out_free;

  bdq_store u_store (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (rdata)
  );

  bdq_alu u_alu (
    .base   (front),
    .offset (alu_offset),
    .a      (rdata),
    .b      (val),
    .addr   (alu_addr),
    .eq     (alu_eq)
  );

  assign full = (count == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
  assign empty = (count == '0);
  assign pos_ok = (bdq_pkg::CMP_W'(pos) < bdq_pkg::CMP_W'(count));
  assign issue = (idx < count);
  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == bdq_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      bdq_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = bdq_pkg::S_EXEC;
        end
      end
      bdq_pkg::S_EXEC: begin
        case (op)
          bdq_pkg::OP_FIND: state_next = empty ? bdq_pkg::S_FIN : bdq_pkg::S_SCAN;
          bdq_pkg::OP_READ: state_next = pos_ok ? bdq_pkg::S_RDWAIT : bdq_pkg::S_FIN;
          default:          state_next = bdq_pkg::S_FIN;
        endcase
      end
      bdq_pkg::S_RDWAIT: state_next = bdq_pkg::S_FIN;
      bdq_pkg::S_SCAN: begin
        if ((pend && alu_eq) || !issue) begin
          state_next = bdq_pkg::S_FIN;
        end
      end
      bdq_pkg::S_FIN: begin
        if (out_free) begin
          state_next = bdq_pkg::S_IDLE;
        end
      end
      default: state_next = bdq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    front_next = front;
    count_next = count;
    idx_next = idx;
    pend_next = pend;
    pend_idx_next = pend_idx;
    res_status_next = res_status;
    res_value_next = res_value;
    res_pos_next = res_pos;
    alu_offset = '0;
    mreq.we = 1'b0;
    mreq.waddr = alu_addr;
    mreq.wdata = val;
    mreq.re = 1'b0;
    mreq.raddr = alu_addr;
    case (state)
      bdq_pkg::S_EXEC: begin
        res_status_next = bdq_pkg::STAT_OK;
        res_value_next = '0;
        res_pos_next = '0;
        idx_next = '0;
        pend_next = 1'b0;
        case (op)
          bdq_pkg::OP_PUSH_FRONT: begin
            alu_offset = bdq_pkg::PTR_W'(bdq_pkg::DEPTH - 1);
            if (full) begin
              res_status_next = bdq_pkg::STAT_FULL;
            end else begin
              mreq.we = 1'b1;
              front_next = alu_addr;
              count_next = count + 1'b1;
            end
          end
          bdq_pkg::OP_PUSH_BACK: begin
            alu_offset = count[bdq_pkg::PTR_W-1:0];
            if (full) begin
              res_status_next = bdq_pkg::STAT_FULL;
            end else begin
              mreq.we = 1'b1;
              count_next = count + 1'b1;
            end
          end
          bdq_pkg::OP_POP_FRONT: begin
            alu_offset = bdq_pkg::PTR_W'(1);
            if (empty) begin
              res_status_next = bdq_pkg::STAT_EMPTY;
            end else begin
              front_next = alu_addr;
              count_next = count - 1'b1;
            end
          end
          bdq_pkg::OP_POP_BACK: begin
            if (empty) begin
              res_status_next = bdq_pkg::STAT_EMPTY;
            end else begin
              count_next = count - 1'b1;
            end
          end
          bdq_pkg::OP_FIND: begin
            if (empty) begin
              res_status_next = bdq_pkg::STAT_NOTFOUND;
            end
          end
          bdq_pkg::OP_READ: begin
            alu_offset = bdq_pkg::PTR_W'(pos);
            if (pos_ok) begin
              mreq.re = 1'b1;
            end else begin
              res_status_next = bdq_pkg::STAT_NOTFOUND;
            end
          end
          default: res_status_next = bdq_pkg::STAT_NOTFOUND;
        endcase
      end
      bdq_pkg::S_RDWAIT: begin
        res_value_next = rdata;
      end
      bdq_pkg::S_SCAN: begin
        alu_offset = idx[bdq_pkg::PTR_W-1:0];
        if (pend && alu_eq) begin
          res_status_next = bdq_pkg::STAT_OK;
          res_pos_next = pend_idx;
          pend_next = 1'b0;
        end else if (!issue) begin
          res_status_next = bdq_pkg::STAT_NOTFOUND;
          pend_next = 1'b0;
        end else begin
          mreq.re = 1'b1;
          pend_next = 1'b1;
          pend_idx_next = idx[bdq_pkg::PTR_W-1:0];
          idx_next = idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdq_pkg::S_IDLE;
      front <= '0;
      count <= '0;
      pend <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      pend <= pend_next;
      if (state == bdq_pkg::S_FIN && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == bdq_pkg::S_IDLE && req.valid) begin
      op <= bdq_pkg::op_t'(req.opcode);
      val <= req.value;
      pos <= req.position;
    end
    idx <= idx_next;
    pend_idx <= pend_idx_next;
    res_status <= res_status_next;
    res_value <= res_value_next;
    res_pos <= res_pos_next;
    if (state == bdq_pkg::S_FIN && out_free) begin
      rsp.status <= res_status;
      rsp.result_value <= res_value;
      rsp.result_position <= bdq_pkg::POSITION_W'(res_pos);
      rsp.entry_count <= bdq_pkg::COUNT_W'(count);
    end
  end

endmodule

// ----- design/bdq_store.sv -----
// Entry store of the bounded deque: one write port and one registered read port.
// Depends on bdq_pkg for the depth and the memory request struct.
module bdq_store (
  input  logic                            clk,
  input  bdq_pkg::mem_req_t               mreq,
  output logic [bdq_pkg::VALUE_W-1:0]     rdata
);

  logic [bdq_pkg::VALUE_W-1:0] mem [bdq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.waddr] <= mreq.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.re) begin
      rdata <= mem[mreq.raddr];
    end
  end

endmodule

// ----- design/bdq_alu.sv -----
// Shared ring address adder and value comparator of the bounded deque.
// Depends on bdq_pkg for the depth and widths.
module bdq_alu (
  input  logic [bdq_pkg::PTR_W-1:0]   base,
  input  logic [bdq_pkg::PTR_W-1:0]   offset,
  input  logic [bdq_pkg::VALUE_W-1:0] a,
  input  logic [bdq_pkg::VALUE_W-1:0] b,
  output logic [bdq_pkg::PTR_W-1:0]   addr,
  output logic                        eq
);

  logic [bdq_pkg::PTR_W:0] sum;

  always_comb begin
    sum = {1'b0, base} + {1'b0, offset};
    if (sum >= (bdq_pkg::PTR_W+1)'(bdq_pkg::DEPTH)) begin
      sum = sum - (bdq_pkg::PTR_W+1)'(bdq_pkg::DEPTH);
    end
    addr = sum[bdq_pkg::PTR_W-1:0];
    eq = (a == b);
  end

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for bounded_deque_with_search: random and directed requests
// are checked against a cycle-free deque predictor, response by response, in order.
// Depends on bdq_pkg, the bdq_in_if and bdq_out_if interfaces and the design top level.
module tb;

  localparam logic [bdq_pkg::OPCODE_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [bdq_pkg::OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;
  localparam logic signed [bdq_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [bdq_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [bdq_pkg::OPCODE_W-1:0]          opcode;
    logic signed [bdq_pkg::VALUE_W-1:0]    value;
    logic [bdq_pkg::POSITION_W-1:0]        position;
  } deque_cmd_t;

  typedef struct packed {
    logic [bdq_pkg::STATUS_W-1:0]          status;
    logic signed [bdq_pkg::VALUE_W-1:0]    result_value;
    logic [bdq_pkg::POSITION_W-1:0]        result_position;
    logic [bdq_pkg::COUNT_W-1:0]           entry_count;
  } deque_reply_t;

  typedef struct {
    deque_cmd_t cmd;
    bit         wait_for_drain;
  } queued_cmd_t;

  logic clk;
  logic rst;

  bdq_in_if req_ch ();
  bdq_out_if rsp_ch ();

  bounded_deque_with_search uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  queued_cmd_t pending_cmds[$];
  deque_reply_t awaited_replies[$];
  queued_cmd_t next_cmd;
  deque_cmd_t offered_cmd;
  deque_reply_t arrived_want;

  logic signed [bdq_pkg::VALUE_W-1:0] shadow_store [bdq_pkg::DEPTH];
  int shadow_front = 0;
  int shadow_count = 0;

  logic signed [bdq_pkg::VALUE_W-1:0] value_pool [8];
  int pool_slot = 0;

  int requests_sent = 0;
  int replies_seen = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  function automatic deque_reply_t deque_apply(deque_cmd_t cmd);
    deque_reply_t r;
    bit hit;
    r = '0;
    r.status = bdq_pkg::STAT_OK;
    hit = 1'b0;
    case (cmd.opcode)
      bdq_pkg::OP_PUSH_FRONT: begin
        if (shadow_count >= bdq_pkg::DEPTH) begin
          r.status = bdq_pkg::STAT_FULL;
        end else begin
          shadow_front = (shadow_front + bdq_pkg::DEPTH - 1) % bdq_pkg::DEPTH;
          shadow_store[shadow_front] = cmd.value;
          shadow_count++;
        end
      end
      bdq_pkg::OP_PUSH_BACK: begin
        if (shadow_count >= bdq_pkg::DEPTH) begin
          r.status = bdq_pkg::STAT_FULL;
        end else begin
          shadow_store[(shadow_front + shadow_count) % bdq_pkg::DEPTH] = cmd.value;
          shadow_count++;
        end
      end
      bdq_pkg::OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = bdq_pkg::STAT_EMPTY;
        end else begin
          shadow_front = (shadow_front + 1) % bdq_pkg::DEPTH;
          shadow_count--;
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = bdq_pkg::STAT_EMPTY;
        end else begin
          shadow_count--;
        end
      end
      bdq_pkg::OP_FIND: begin
        r.status = bdq_pkg::STAT_NOTFOUND;
        for (int i = 0; i < shadow_count; i++) begin
          if (!hit && shadow_store[(shadow_front + i) % bdq_pkg::DEPTH] == cmd.value) begin
            hit = 1'b1;
            r.status = bdq_pkg::STAT_OK;
            r.result_position = bdq_pkg::POSITION_W'(i);
          end
        end
      end
      bdq_pkg::OP_READ: begin
        if (int'(cmd.position) < shadow_count) begin
          r.result_value =
            shadow_store[(shadow_front + int'(cmd.position)) % bdq_pkg::DEPTH];
        end else begin
          r.status = bdq_pkg::STAT_NOTFOUND;
        end
      end
      default: begin
        r.status = bdq_pkg::STAT_NOTFOUND;
      end
    endcase
    r.entry_count = bdq_pkg::COUNT_W'(shadow_count);
    return r;
  endfunction

  function automatic logic signed [bdq_pkg::VALUE_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return -1;
      4: return $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic void compare_field(string field, logic [bdq_pkg::VALUE_W-1:0] want,
                                        logic [bdq_pkg::VALUE_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic add_cmd(logic [bdq_pkg::OPCODE_W-1:0] opcode,
                         logic signed [bdq_pkg::VALUE_W-1:0] value,
                         logic [bdq_pkg::POSITION_W-1:0] position,
                         bit wait_for_drain = 1'b0);
    queued_cmd_t q;
    q.cmd.opcode = opcode;
    q.cmd.value = value;
    q.cmd.position = position;
    q.wait_for_drain = wait_for_drain;
    pending_cmds.push_back(q);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        awaited_replies.push_back(deque_apply(offered_cmd));
        requests_sent++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_cmds.size() != 0
            && !(pending_cmds[0].wait_for_drain && awaited_replies.size() != 0)
            && ((requests_sent >= 700 && requests_sent < 900)
                || $urandom_range(0, 99) >= 30)) begin
          next_cmd = pending_cmds.pop_front();
          offered_cmd = next_cmd.cmd;
          req_ch.valid <= 1'b1;
          req_ch.opcode <= offered_cmd.opcode;
          req_ch.value <= offered_cmd.value;
          req_ch.position <= offered_cmd.position;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_replies.size() == 0) begin
          $error("response arrived with no request outstanding");
          mismatch_count++;
        end else begin
          arrived_want = awaited_replies.pop_front();
          compare_field("status", bdq_pkg::VALUE_W'(arrived_want.status),
                        bdq_pkg::VALUE_W'(rsp_ch.status));
          compare_field("result_value", arrived_want.result_value, rsp_ch.result_value);
          compare_field("result_position", bdq_pkg::VALUE_W'(arrived_want.result_position),
                        bdq_pkg::VALUE_W'(rsp_ch.result_position));
          compare_field("entry_count", bdq_pkg::VALUE_W'(arrived_want.entry_count),
                        bdq_pkg::VALUE_W'(rsp_ch.entry_count));
        end
        replies_seen++;
        if (replies_seen == 300) begin
          hold_left = 250;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= (replies_seen >= 700 && replies_seen < 900)
                        || $urandom_range(0, 99) >= 30;
      end
    end
  end

  initial begin
    int made;
    int mode;
    int burst;
    int roll;
    logic [bdq_pkg::OPCODE_W-1:0] pick_op;
    logic signed [bdq_pkg::VALUE_W-1:0] pick_value;

    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = '0;
    req_ch.value = '0;
    req_ch.position = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < 8; i++) begin
      value_pool[i] = '0;
    end

    // Empty deque first: pops, find and read must all fail, as must unused opcodes.
    add_cmd(bdq_pkg::OP_POP_FRONT, VAL_MAX, 4'd15);
    add_cmd(bdq_pkg::OP_POP_BACK, VAL_MIN, 4'd0);
    add_cmd(bdq_pkg::OP_FIND, '0, 4'd0);
    add_cmd(bdq_pkg::OP_READ, '0, 4'd0);
    add_cmd(OP_UNUSED_LO, -1, 4'd15);
    add_cmd(OP_UNUSED_HI, VAL_MIN, 4'd7);
    add_cmd(bdq_pkg::OP_PUSH_FRONT, VAL_MIN, 4'd0);
    add_cmd(bdq_pkg::OP_PUSH_BACK, VAL_MAX, 4'd15);
    add_cmd(bdq_pkg::OP_PUSH_FRONT, -1, 4'd0);
    add_cmd(bdq_pkg::OP_PUSH_BACK, '0, 4'd0);
    add_cmd(bdq_pkg::OP_FIND, VAL_MAX, 4'd0);
    add_cmd(bdq_pkg::OP_FIND, '0, 4'd0);
    add_cmd(bdq_pkg::OP_FIND, 32'sd12345, 4'd0);
    add_cmd(bdq_pkg::OP_READ, '0, 4'd3);
    add_cmd(bdq_pkg::OP_READ, '0, 4'd0);
    add_cmd(bdq_pkg::OP_READ, '0, 4'd4);
    add_cmd(bdq_pkg::OP_READ, '0, 4'd15);
    add_cmd(OP_UNUSED_HI, '0, 4'd0);
    add_cmd(bdq_pkg::OP_POP_FRONT, '0, 4'd0);
    add_cmd(bdq_pkg::OP_POP_BACK, '0, 4'd0);
    add_cmd(bdq_pkg::OP_READ, '0, 4'd1);

    // Fill past capacity, then search and read at both ends.
    for (int i = 0; i < bdq_pkg::DEPTH + 2; i++) begin
      pick_value = random_value();
      value_pool[i % 8] = pick_value;
      add_cmd(($urandom_range(0, 1) != 0) ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT,
              pick_value, bdq_pkg::POSITION_W'($urandom_range(0, 15)));
    end
    add_cmd(bdq_pkg::OP_FIND, value_pool[$urandom_range(0, 7)], 4'd0);
    add_cmd(bdq_pkg::OP_READ, '0, 4'd15);
    add_cmd(bdq_pkg::OP_READ, '0, 4'd0);

    made = 0;
    while (made < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      burst = $urandom_range(8, 40);
      for (int k = 0; k < burst; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < (mode == 0 ? 55 : mode == 1 ? 20 : 30)) begin
          pick_op = ($urandom_range(0, 1) != 0) ? bdq_pkg::OP_PUSH_BACK
                                                : bdq_pkg::OP_PUSH_FRONT;
        end else if (roll < (mode == 0 ? 70 : mode == 1 ? 65 : 45)) begin
          pick_op = ($urandom_range(0, 1) != 0) ? bdq_pkg::OP_POP_BACK
                                                : bdq_pkg::OP_POP_FRONT;
        end else if (roll < (mode == 0 ? 85 : mode == 1 ? 82 : 70)) begin
          pick_op = bdq_pkg::OP_FIND;
        end else if (roll < 97) begin
          pick_op = bdq_pkg::OP_READ;
        end else begin
          pick_op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_HI : OP_UNUSED_LO;
        end
        if ((pick_op == bdq_pkg::OP_FIND && $urandom_range(0, 99) < 70)
            || ((pick_op == bdq_pkg::OP_PUSH_FRONT || pick_op == bdq_pkg::OP_PUSH_BACK)
                && $urandom_range(0, 99) < 25)) begin
          pick_value = value_pool[$urandom_range(0, 7)];
        end else begin
          pick_value = random_value();
        end
        if (pick_op == bdq_pkg::OP_PUSH_FRONT || pick_op == bdq_pkg::OP_PUSH_BACK) begin
          value_pool[pool_slot] = pick_value;
          pool_slot = (pool_slot + 1) % 8;
        end
        add_cmd(pick_op, pick_value, bdq_pkg::POSITION_W'($urandom_range(0, 15)),
                made == 500);
        made++;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || req_ch.valid || awaited_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (bdq_pkg::DEPTH + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/bdq_pkg.sv
design/bdq_if.sv
design/bdq_store.sv
design/bdq_alu.sv
design/bounded_deque_with_search.sv
tb/sv/tb.sv
